// ===== rtl/core/tsp_pkg.sv =====
// tsp_pkg: shared types and codes for the two-sum pair finder
// no dependencies; imported by tsp_cell, two_sum_pair_finder and two_sum_pair_finder_tb
`timescale 1ns / 1ps

package tsp_pkg;

	localparam int OUT_IDX_W = 6;
	localparam int STATUS_W  = 2;

	localparam logic [STATUS_W-1:0] STATUS_PAIR     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_PAIR  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	// control flags that travel with a request down the cell row
	typedef struct packed {
		logic active;
		logic hit;
		logic dup;
		logic last;
	} tok_ctl_t;

endpackage

// ===== rtl/core/tsp_cell.sv =====
// tsp_cell: one table entry of the pair finder plus the token register to the next cell
// depends on tsp_pkg
`timescale 1ns / 1ps

module tsp_cell
	import tsp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int IDX_W       = 6,
	parameter int CELL_IDX    = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tok_ctl_t               ctl_in,
	input  logic [VALUE_WIDTH:0]   comp_in,
	input  logic [VALUE_WIDTH-1:0] elem_in,
	input  logic [IDX_W-1:0]       idx_in,
	input  logic [IDX_W-1:0]       hit_idx_in,
	output tok_ctl_t               ctl_out,
	output logic [VALUE_WIDTH:0]   comp_out,
	output logic [VALUE_WIDTH-1:0] elem_out,
	output logic [IDX_W-1:0]       idx_out,
	output logic [IDX_W-1:0]       hit_idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                   valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [IDX_W-1:0]       index_q;

	tok_ctl_t               ctl_q;
	logic [VALUE_WIDTH:0]   comp_q;
	logic [VALUE_WIDTH-1:0] elem_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       hit_idx_q;

	logic     check;
	logic     at_slot;
	logic     hit_here;
	logic     dup_here;
	tok_ctl_t ctl_nxt;

	always_comb begin
		check    = ctl_in.active && (MY_IDX < idx_in) && valid_q && !ctl_in.hit;
		at_slot  = ctl_in.active && (MY_IDX == idx_in);
		hit_here = check && ({value_q[VALUE_WIDTH-1], value_q} == comp_in);
		dup_here = check && !hit_here && (value_q == elem_in);
		ctl_nxt     = ctl_in;
		ctl_nxt.hit = ctl_in.hit | hit_here;
		ctl_nxt.dup = ctl_in.dup | dup_here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			ctl_q <= ctl_nxt;
			if (at_slot) begin
				valid_q <= !ctl_in.hit && !ctl_in.dup;
			end
		end
	end

	always_ff @(posedge clk) begin
		comp_q    <= comp_in;
		elem_q    <= elem_in;
		idx_q     <= idx_in;
		hit_idx_q <= hit_here ? index_q : hit_idx_in;
		if (at_slot) begin
			value_q <= elem_in;
			index_q <= idx_in;
		end else if (dup_here) begin
			index_q <= idx_in;
		end
	end

	assign ctl_out     = ctl_q;
	assign comp_out    = comp_q;
	assign elem_out    = elem_q;
	assign idx_out     = idx_q;
	assign hit_idx_out = hit_idx_q;

endmodule

// ===== rtl/core/two_sum_pair_finder.sv =====
// two_sum_pair_finder: an accepted request is registered in an input stage, then steps
// one cell a cycle through the MAX_ITEMS-cell table row, and its strobe comes from a result register;
// one request in flight, with busy held until the request reaches the end of the row.
// an overflow result comes in the cycle after the request; ignored requests raise no busy and give no result.
// async active-low reset: target 0, empty array state; results cannot be stalled.
// depends on tsp_pkg and tsp_cell
`timescale 1ns / 1ps

module two_sum_pair_finder
	import tsp_pkg::*;
#(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [VALUE_WIDTH-1:0] wr_data,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] element_value,
	input  logic                   first_item,
	input  logic                   last_item,
	output logic                   result_valid,
	output logic [OUT_IDX_W-1:0]   earlier_index,
	output logic [OUT_IDX_W-1:0]   later_index,
	output logic [STATUS_W-1:0]    status
);

	localparam int IDX_W  = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int WIDE_W = IDX_W + OUT_IDX_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

	logic [VALUE_WIDTH-1:0] target_q;
	logic [CNT_W-1:0]       count_q;
	logic                   done_q;
	logic                   busy_q;

	tok_ctl_t               ctl_s0;
	logic [VALUE_WIDTH:0]   comp_s0;
	logic [VALUE_WIDTH-1:0] elem_s0;
	logic [IDX_W-1:0]       idx_s0;

	logic                   result_valid_q;
	logic [OUT_IDX_W-1:0]   earlier_q;
	logic [OUT_IDX_W-1:0]   later_q;
	logic [STATUS_W-1:0]    status_q;

	tok_ctl_t               ctl_c     [0:MAX_ITEMS];
	logic [VALUE_WIDTH:0]   comp_c    [0:MAX_ITEMS];
	logic [VALUE_WIDTH-1:0] elem_c    [0:MAX_ITEMS];
	logic [IDX_W-1:0]       idx_c     [0:MAX_ITEMS];
	logic [IDX_W-1:0]       hit_idx_c [0:MAX_ITEMS];

	logic                   accept;
	logic [CNT_W-1:0]       count_eff;
	logic                   done_eff;
	logic                   launch;
	logic                   overflow;
	logic [VALUE_WIDTH:0]   comp_nxt;
	tok_ctl_t               exit_ctl;
	tok_ctl_t               ctl_nxt;
	logic                   result_nxt;
	logic [WIDE_W-1:0]      earlier_wide;
	logic [WIDE_W-1:0]      later_wide;

	always_comb begin
		accept    = start && !busy_q;
		count_eff = first_item ? '0 : count_q;
		done_eff  = first_item ? 1'b0 : done_q;
		overflow  = accept && !done_eff && (count_eff >= CNT_MAX);
		launch    = accept && !done_eff && (count_eff < CNT_MAX);
		comp_nxt  = {target_q[VALUE_WIDTH-1], target_q}
			- {element_value[VALUE_WIDTH-1], element_value};
		exit_ctl     = ctl_c[MAX_ITEMS];
		earlier_wide = WIDE_W'(hit_idx_c[MAX_ITEMS]);
		later_wide   = WIDE_W'(idx_c[MAX_ITEMS]);
		ctl_nxt        = '0;
		ctl_nxt.active = launch;
		ctl_nxt.last   = launch && last_item;
		result_nxt     = overflow
			|| (!accept && exit_ctl.active && (exit_ctl.hit || exit_ctl.last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= '0;
			count_q        <= '0;
			done_q         <= 1'b0;
			busy_q         <= 1'b0;
			ctl_s0         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				target_q <= wr_data;
			end
			result_valid_q <= result_nxt;
			ctl_s0         <= ctl_nxt;
			priority if (launch) begin
				count_q <= count_eff + CNT_W'(1);
				done_q  <= 1'b0;
				busy_q  <= 1'b1;
			end else if (accept) begin
				count_q <= count_eff;
				done_q  <= 1'b1;
			end else if (exit_ctl.active) begin
				busy_q <= 1'b0;
				if (exit_ctl.hit || exit_ctl.last) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		comp_s0 <= comp_nxt;
		elem_s0 <= element_value;
		idx_s0  <= count_eff[IDX_W-1:0];
		if (overflow) begin
			earlier_q <= '0;
			later_q   <= '0;
			status_q  <= STATUS_OVERFLOW;
		end else if (exit_ctl.hit) begin
			earlier_q <= earlier_wide[OUT_IDX_W-1:0];
			later_q   <= later_wide[OUT_IDX_W-1:0];
			status_q  <= STATUS_PAIR;
		end else begin
			earlier_q <= '0;
			later_q   <= '0;
			status_q  <= STATUS_NO_PAIR;
		end
	end

	assign ctl_c[0]     = ctl_s0;
	assign comp_c[0]    = comp_s0;
	assign elem_c[0]    = elem_s0;
	assign idx_c[0]     = idx_s0;
	assign hit_idx_c[0] = '0;

	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		tsp_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.IDX_W      (IDX_W),
			.CELL_IDX   (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl_in     (ctl_c[g]),
			.comp_in    (comp_c[g]),
			.elem_in    (elem_c[g]),
			.idx_in     (idx_c[g]),
			.hit_idx_in (hit_idx_c[g]),
			.ctl_out    (ctl_c[g+1]),
			.comp_out   (comp_c[g+1]),
			.elem_out   (elem_c[g+1]),
			.idx_out    (idx_c[g+1]),
			.hit_idx_out(hit_idx_c[g+1])
		);
	end

	assign busy          = busy_q;
	assign result_valid  = result_valid_q;
	assign earlier_index = earlier_q;
	assign later_index   = later_q;
	assign status        = status_q;

endmodule

// ===== tb/two_sum_pair_finder_tb.sv =====
// two_sum_pair_finder_tb: self-checking bench for the two-sum pair finder, directed table, then
// overflow and random arrays; results checked against typed table rows or an in-bench pair predictor
// depends on tsp_pkg and two_sum_pair_finder
`timescale 1ns / 1ps

module two_sum_pair_finder_tb;
	import tsp_pkg::*;

	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int LATENCY     = MAX_ITEMS + 2;
	localparam int ITEMS       = 950;
	localparam int QUIET_TAIL  = 150;
	localparam int STALL_LIMIT = 8 * (LATENCY + 12 + LATENCY + 8);
	localparam int N_DIR       = 24;

	typedef logic [VALUE_WIDTH-1:0] val_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] earlier;
		logic [OUT_IDX_W-1:0] later;
		logic [STATUS_W-1:0]  st;
	} pair_res_t;

	typedef enum logic [1:0] {
		ROW_PRED,
		ROW_NONE,
		ROW_EXP
	} row_kind_e;

	typedef struct packed {
		logic      set_tgt;
		val_t      tgt;
		val_t      val;
		logic      first;
		logic      last;
		row_kind_e kind;
		pair_res_t res;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	val_t                 wr_data;
	logic                 start;
	logic                 busy;
	val_t                 element_value;
	logic                 first_item;
	logic                 last_item;
	logic                 result_valid;
	logic [OUT_IDX_W-1:0] earlier_index;
	logic [OUT_IDX_W-1:0] later_index;
	logic [STATUS_W-1:0]  status;

	// predictor state
	longint          seen_val [MAX_ITEMS];
	logic [5:0]      seen_idx [MAX_ITEMS];
	bit              seen_ok  [MAX_ITEMS];
	int unsigned     n_taken;
	bit              array_closed;
	val_t            target_copy;

	pair_res_t       pending_pairs [$];
	dir_row_t        dir_tab [N_DIR];

	int              n_err;
	int              n_req;
	int              n_used;
	int              n_checked;
	int              n_pair;
	int              n_nopair;
	int              n_ovf;
	int              n_cfg;
	int              gap_pct;
	int              idle_cycles;

	two_sum_pair_finder #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_data      (wr_data),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.first_item   (first_item),
		.last_item    (last_item),
		.result_valid (result_valid),
		.earlier_index(earlier_index),
		.later_index  (later_index),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_pairs();
		for (int k = 0; k < MAX_ITEMS; k++) begin
			seen_ok[k]  = 1'b0;
			seen_val[k] = 0;
			seen_idx[k] = '0;
		end
		n_taken      = 0;
		array_closed = 1'b0;
	endfunction

	function automatic void queue_expected(input pair_res_t r);
		pending_pairs.insert(pending_pairs.size(), r);
	endfunction

	// one request through the pair search; used is low for an ignored request
	function automatic void twosum_predict(input val_t v, input logic f, input logic l,
			output bit has, output bit used, output pair_res_t r);
		longint     comp;
		longint     elem;
		int unsigned idx;
		int         slot;
		has  = 1'b0;
		used = 1'b0;
		r    = '0;
		if (f)
			clear_pairs();
		if (array_closed)
			return;
		used = 1'b1;
		if (n_taken >= MAX_ITEMS) begin
			array_closed = 1'b1;
			has = 1'b1;
			r.st = STATUS_OVERFLOW;
			return;
		end
		idx     = n_taken;
		n_taken = n_taken + 1;
		elem    = longint'($signed(v));
		comp    = longint'($signed(target_copy)) - elem;
		for (int k = 0; k < MAX_ITEMS; k++) begin
			if (seen_ok[k] && seen_val[k] == comp) begin
				array_closed = 1'b1;
				has = 1'b1;
				r.earlier = seen_idx[k];
				r.later   = idx[5:0];
				r.st      = STATUS_PAIR;
				return;
			end
		end
		slot = idx;
		for (int k = MAX_ITEMS - 1; k >= 0; k--) begin
			if (seen_ok[k] && seen_val[k] == elem)
				slot = k;
		end
		seen_ok[slot]  = 1'b1;
		seen_val[slot] = elem;
		seen_idx[slot] = idx[5:0];
		if (l) begin
			array_closed = 1'b1;
			has = 1'b1;
			r.st = STATUS_NO_PAIR;
		end
	endfunction

	function automatic val_t pick_value(input int mode);
		val_t v;
		case (mode)
			0: v = val_t'(int'($urandom_range(0, 20)) - 10);
			1: v = $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h0000_0000;
					default: v = 32'hffff_ffff;
				endcase
			end
			default: v = val_t'(($signed(target_copy) >>> 1) + int'($urandom_range(0, 8)) - 4);
		endcase
		return v;
	endfunction

	function automatic val_t pick_target();
		val_t t;
		case ($urandom_range(0, 5))
			0, 1, 2: t = val_t'(int'($urandom_range(0, 32)) - 16);
			3: t = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: t = $urandom;
		endcase
		return t;
	endfunction

	task automatic set_target(input val_t t);
		start <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		while (busy)
			@(posedge clk);
		wr_en   <= 1'b1;
		wr_data <= t;
		@(posedge clk);
		wr_en <= 1'b0;
		target_copy = t;
		n_cfg++;
	endtask

	task automatic send_req(input val_t v, input logic f, input logic l,
			input row_kind_e kind, input pair_res_t typed);
		bit        has;
		bit        used;
		pair_res_t r;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			if ($urandom_range(0, 1) != 0) begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
			end
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start         <= 1'b1;
		element_value <= v;
		first_item    <= f;
		last_item     <= l;
		do
			@(posedge clk);
		while (busy);
		twosum_predict(v, f, l, has, used, r);
		n_req++;
		if (used)
			n_used++;
		case (kind)
			ROW_PRED: if (has) queue_expected(r);
			ROW_EXP:  queue_expected(typed);
			default:  ;
		endcase
	endtask

	// values with the top two bits 01 sum past the signed range, so no pair can form
	task automatic long_array(input int len, input bit closed);
		for (int j = 0; j < len; j++)
			send_req({2'b01, 30'($urandom)}, j == 0, closed && j == len - 1, ROW_PRED, '0);
	endtask

	always @(posedge clk) begin : chk_results
		pair_res_t want;
		if (arst_n && result_valid) begin
			if (pending_pairs.size() == 0) begin
				$error("unexpected result: earlier %0d later %0d status %0d",
					earlier_index, later_index, status);
				n_err++;
			end else begin
				want = pending_pairs.pop_front();
				n_checked++;
				case (want.st)
					STATUS_PAIR:     n_pair++;
					STATUS_NO_PAIR:  n_nopair++;
					default:         n_ovf++;
				endcase
				if (earlier_index !== want.earlier) begin
					$error("earlier_index: expected %0d, actual %0d", want.earlier, earlier_index);
					n_err++;
				end
				if (later_index !== want.later) begin
					$error("later_index: expected %0d, actual %0d", want.later, later_index);
					n_err++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					n_err++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || wr_en) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int vmode;
		int pick;
		bit closed;
		arst_n        <= 1'b0;
		wr_en         <= 1'b0;
		wr_data       <= '0;
		start         <= 1'b0;
		element_value <= '0;
		first_item    <= 1'b0;
		last_item     <= 1'b0;
		n_err = 0; n_req = 0; n_used = 0; n_checked = 0;
		n_pair = 0; n_nopair = 0; n_ovf = 0; n_cfg = 0;
		target_copy = '0;
		clear_pairs();

		// set_tgt, target, value, first, last, kind, typed result
		dir_tab = '{
			'{1'b0, 32'd0,          32'd5,          1'b0, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          -32'sd5,        1'b0, 1'b0, ROW_EXP,  '{6'd0, 6'd1, STATUS_PAIR}},
			'{1'b0, 32'd0,          32'd7,          1'b0, 1'b0, ROW_NONE, '0},
			'{1'b1, 32'd10,         32'd3,          1'b1, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'd3,          1'b0, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'd7,          1'b0, 1'b0, ROW_EXP,  '{6'd1, 6'd2, STATUS_PAIR}},
			'{1'b0, 32'd0,          32'd9,          1'b0, 1'b1, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'd0,          1'b1, 1'b1, ROW_EXP,  '{6'd0, 6'd0, STATUS_NO_PAIR}},
			'{1'b0, 32'd0,          32'd4,          1'b1, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'd6,          1'b0, 1'b1, ROW_EXP,  '{6'd0, 6'd1, STATUS_PAIR}},
			'{1'b1, 32'hffff_ffff,  32'h7fff_ffff,  1'b1, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'h8000_0000,  1'b0, 1'b1, ROW_EXP,  '{6'd0, 6'd1, STATUS_PAIR}},
			'{1'b1, 32'h8000_0000,  32'h7fff_ffff,  1'b1, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'h7fff_ffff,  1'b0, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'h8000_0000,  1'b0, 1'b1, ROW_EXP,  '{6'd0, 6'd0, STATUS_NO_PAIR}},
			'{1'b1, 32'h7fff_ffff,  32'h8000_0000,  1'b1, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'hffff_ffff,  1'b0, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'd0,          1'b1, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'h7fff_ffff,  1'b0, 1'b1, ROW_EXP,  '{6'd0, 6'd1, STATUS_PAIR}},
			'{1'b1, 32'd0,          32'h1234_5678,  1'b0, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'd0,          1'b1, 1'b0, ROW_NONE, '0},
			'{1'b0, 32'd0,          32'd0,          1'b0, 1'b0, ROW_EXP,  '{6'd0, 6'd1, STATUS_PAIR}},
			'{1'b0, 32'd0,          32'h5a5a_5a5a,  1'b1, 1'b0, ROW_PRED, '0},
			'{1'b0, 32'd0,          32'ha5a5_a5a5,  1'b0, 1'b1, ROW_PRED, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 30;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_tgt)
				set_target(dir_tab[i].tgt);
			send_req(dir_tab[i].val, dir_tab[i].first, dir_tab[i].last,
				dir_tab[i].kind, dir_tab[i].res);
		end

		// table overflow, then a full table closed by its last request
		long_array(MAX_ITEMS + 1, 1'b0);
		send_req(32'd1, 1'b0, 1'b0, ROW_PRED, '0);
		long_array(MAX_ITEMS, 1'b1);

		while (n_req < ITEMS) begin
			if (n_req >= ITEMS - QUIET_TAIL)
				gap_pct = 0;
			else
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
			if (n_req < ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
				set_target(pick_target());
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				long_array($urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 4), $urandom_range(0, 1) != 0);
			end else if (pick < 75) begin
				len    = $urandom_range(1, 12);
				vmode  = $urandom_range(0, 3);
				closed = $urandom_range(0, 4) != 0;
				for (int j = 0; j < len; j++)
					send_req(pick_value(vmode), j == 0 && $urandom_range(0, 9) != 0,
						closed && j == len - 1, ROW_PRED, '0);
			end else begin
				len = $urandom_range(1, 8);
				for (int j = 0; j < len; j++)
					send_req(pick_value($urandom_range(0, 3)), $urandom_range(0, 5) == 0,
						$urandom_range(0, 3) == 0, ROW_PRED, '0);
			end
		end

		start <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (pending_pairs.size() != 0) begin
			$error("%0d results never arrived", pending_pairs.size());
			n_err++;
		end

		$display("ran %0d requests (%0d ignored) across %0d target settings",
			n_req, n_req - n_used, n_cfg);
		$display("checked %0d results: %0d pairs, %0d with no pair, %0d overflows",
			n_checked, n_pair, n_nopair, n_ovf);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
